// ===== design/cbba_pkg.sv =====
// Shared types and codes for the contiguous block bitmap allocator.
package cbba_pkg;

    localparam logic       MODE_ALLOC   = 1'b0;
    localparam logic       MODE_RELEASE = 1'b1;

    localparam logic [1:0] ST_DONE      = 2'd0;
    localparam logic [1:0] ST_NO_ROOM   = 2'd1;
    localparam logic [1:0] ST_BAD       = 2'd2;

    typedef struct packed {
        logic wr;
        logic val;
    } t_map_cmd;

    typedef struct packed {
        logic clear;
        logic preset;
        logic step;
    } t_acc_cmd;

endpackage

// ===== design/cbba_map.sv =====
// Block usage bitmap with one-bit write and one-bit read.
module cbba_map import cbba_pkg::*; #(
    parameter int BLOCKS = 54,
    parameter int IW     = 6
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_map_cmd      i_cmd,
    input  logic [IW-1:0] i_idx,
    output logic          o_used
);

    logic [BLOCKS-1:0] r_map;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map <= '0;
        end else if (i_cmd.wr) begin
            r_map[i_idx] <= i_cmd.val;
        end
    end

    assign o_used = r_map[i_idx];

endmodule

// ===== design/cbba_acc_unit.sv =====
// Shared accumulator: clears to zero, presets to or steps by one block size, and compares below an operand.
module cbba_acc_unit import cbba_pkg::*; #(
    parameter int BLOCK_BYTES = 512,
    parameter int AW          = 18
) (
    input  logic          i_clk,
    input  t_acc_cmd      i_cmd,
    input  logic [AW-1:0] i_op,
    output logic          o_lt
);

    logic [AW-1:0] r_acc;
    logic [AW-1:0] n_acc;

    always_comb begin
        n_acc = r_acc;
        priority if (i_cmd.clear) begin
            n_acc = '0;
        end else if (i_cmd.preset) begin
            n_acc = AW'(BLOCK_BYTES);
        end else if (i_cmd.step) begin
            n_acc = r_acc + AW'(BLOCK_BYTES);
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
    end

    assign o_lt = (r_acc < i_op);

endmodule

// ===== design/contiguous_block_bitmap_allocator.sv =====
// Top level of the first-fit contiguous block bitmap allocator.
//
// Input channel (i_valid/o_ready) carries a mode, a byte count and a release
// address; output channel (o_valid/i_ready) returns a status and the start
// address of an allocated run. One result per request, in order.
// One request is in flight at a time; o_ready is high only while idle.
// Steps per request, with N = blocks needed (clipped at BLOCKS+1):
//   allocate: count N blocks of size, scan for a free run, mark N blocks used
//   release:  count N blocks of size, locate start block F, clear up to N blocks
// Counting and locating go through one shared accumulator, and scanning and
// marking are a one-bit-per-cycle walk of the bitmap, so the block count bounds latency.
// Synchronous reset clears the bitmap (all blocks free) and returns to idle.
// A result waits in the output register while i_ready is low; no new
// request is taken until it is transferred.
module contiguous_block_bitmap_allocator import cbba_pkg::*; #(
    parameter int BLOCKS      = 54,
    parameter int BLOCK_BYTES = 512,
    parameter int WINDOW_BASE = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_mode,
    input  logic [15:0] i_byte_count,
    input  logic [15:0] i_release_address,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_status,
    output logic [15:0] o_buffer_address
);

    localparam int CW      = $clog2(BLOCKS + 2);
    localparam int IW      = (BLOCKS > 1) ? $clog2(BLOCKS) : 1;
    localparam int AW_MIN  = $clog2((BLOCKS + 1) * BLOCK_BYTES + 1);
    localparam int AW      = (AW_MIN > 18) ? AW_MIN : 18;
    localparam logic [31:0] WIN_END = 32'(WINDOW_BASE + BLOCKS * BLOCK_BYTES);
    localparam logic [CW-1:0] CNT_MAX  = CW'(BLOCKS + 1);
    localparam logic [CW-1:0] POS_END  = CW'(BLOCKS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_NEED,
        S_FIRST,
        S_SCAN,
        S_MARK,
        S_OUT
    } t_state;

    t_state          r_state, n_state;
    logic            r_mode, n_mode;
    logic [15:0]     r_bytes, n_bytes;
    logic [16:0]     r_offset, n_offset;
    logic            r_bad, n_bad;
    logic [CW-1:0]   r_cnt, n_cnt;
    logic [CW-1:0]   r_pos, n_pos;
    logic [CW-1:0]   r_run, n_run;
    logic [CW-1:0]   r_start, n_start;
    logic [1:0]      r_status, n_status;
    logic [15:0]     r_addr, n_addr;

    t_map_cmd        map_cmd;
    t_acc_cmd        acc_cmd;
    logic            map_used;
    logic            acc_lt;
    logic [AW-1:0]   acc_op;
    logic [CW-1:0]   start_c;
    logic [31:0]     alloc_addr;

    cbba_map #(.BLOCKS(BLOCKS), .IW(IW)) u_map (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (map_cmd),
        .i_idx   (r_pos[IW-1:0]),
        .o_used  (map_used)
    );

    cbba_acc_unit #(.BLOCK_BYTES(BLOCK_BYTES), .AW(AW)) u_acc (
        .i_clk (i_clk),
        .i_cmd (acc_cmd),
        .i_op  (acc_op),
        .o_lt  (acc_lt)
    );

    assign acc_op     = (r_state == S_FIRST) ? (AW'(r_offset) + AW'(1)) : AW'(r_bytes);
    assign start_c    = (r_run == '0) ? r_pos : r_start;
    assign alloc_addr = 32'(WINDOW_BASE) + 32'(r_start) * 32'(BLOCK_BYTES);

    always_comb begin
        n_state  = r_state;
        n_mode   = r_mode;
        n_bytes  = r_bytes;
        n_offset = r_offset;
        n_bad    = r_bad;
        n_cnt    = r_cnt;
        n_pos    = r_pos;
        n_run    = r_run;
        n_start  = r_start;
        n_status = r_status;
        n_addr   = r_addr;
        map_cmd  = '0;
        acc_cmd  = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_mode   = i_mode;
                    n_bytes  = i_byte_count;
                    n_offset = 17'(i_release_address) - 17'(WINDOW_BASE);
                    n_bad    = (32'(i_release_address) < 32'(WINDOW_BASE)) ||
                               (32'(i_release_address) >= WIN_END);
                    n_cnt    = '0;
                    acc_cmd.clear = 1'b1;
                    n_state  = S_NEED;
                end
            end
            S_NEED: begin
                if (acc_lt && (r_cnt != CNT_MAX)) begin
                    acc_cmd.step = 1'b1;
                    n_cnt = r_cnt + CW'(1);
                end else if (r_mode == MODE_ALLOC) begin
                    if (r_cnt == '0) begin
                        n_status = ST_BAD;
                        n_addr   = '0;
                        n_state  = S_OUT;
                    end else begin
                        n_pos   = '0;
                        n_run   = '0;
                        n_start = '0;
                        n_state = S_SCAN;
                    end
                end else if (r_bad) begin
                    n_status = ST_BAD;
                    n_addr   = '0;
                    n_state  = S_OUT;
                end else begin
                    acc_cmd.preset = 1'b1;
                    n_pos   = '0;
                    n_state = S_FIRST;
                end
            end
            S_FIRST: begin
                if (acc_lt) begin
                    acc_cmd.step = 1'b1;
                    n_pos = r_pos + CW'(1);
                end else begin
                    n_state = S_MARK;
                end
            end
            S_SCAN: begin
                if (r_pos == POS_END) begin
                    n_status = ST_NO_ROOM;
                    n_addr   = '0;
                    n_state  = S_OUT;
                end else if (map_used) begin
                    n_run = '0;
                    n_pos = r_pos + CW'(1);
                end else if ((r_run + CW'(1)) == r_cnt) begin
                    n_start = start_c;
                    n_pos   = start_c;
                    n_state = S_MARK;
                end else begin
                    n_start = start_c;
                    n_run   = r_run + CW'(1);
                    n_pos   = r_pos + CW'(1);
                end
            end
            S_MARK: begin
                if ((r_cnt == '0) || (r_pos == POS_END)) begin
                    n_status = ST_DONE;
                    n_addr   = (r_mode == MODE_ALLOC) ? alloc_addr[15:0] : 16'd0;
                    n_state  = S_OUT;
                end else begin
                    map_cmd.wr  = 1'b1;
                    map_cmd.val = (r_mode == MODE_ALLOC);
                    n_pos = r_pos + CW'(1);
                    n_cnt = r_cnt - CW'(1);
                end
            end
            S_OUT: begin
                if (i_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_mode   <= n_mode;
        r_bytes  <= n_bytes;
        r_offset <= n_offset;
        r_bad    <= n_bad;
        r_cnt    <= n_cnt;
        r_pos    <= n_pos;
        r_run    <= n_run;
        r_start  <= n_start;
        r_status <= n_status;
        r_addr   <= n_addr;
    end

    assign o_ready          = (r_state == S_IDLE);
    assign o_valid          = (r_state == S_OUT);
    assign o_status         = r_status;
    assign o_buffer_address = r_addr;

    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_ready && o_valid))
        else $error("ready and result valid at once");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status == ST_DONE || o_status == ST_NO_ROOM || o_status == ST_BAD))
        else $error("undefined status code");

    a_fail_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status != ST_DONE)) |-> (o_buffer_address == 16'd0))
        else $error("failed request returned an address");

    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("second request taken while busy");

endmodule

// ===== bench/block_alloc_checker.sv =====
// Checker for the block allocator: tracks the block map, predicts each result and compares.
module block_alloc_checker import cbba_pkg::*; #(
    parameter int BLOCKS      = 54,
    parameter int BLOCK_BYTES = 512,
    parameter int WINDOW_BASE = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_req_valid,
    input  logic        i_req_ready,
    input  logic        i_mode,
    input  logic [15:0] i_byte_count,
    input  logic [15:0] i_release_address,
    input  logic        i_rsp_valid,
    input  logic        i_rsp_ready,
    input  logic [1:0]  i_status,
    input  logic [15:0] i_buffer_address,
    output int          o_fail_count,
    output int          o_pending
);

    localparam int WINDOW_END = WINDOW_BASE + BLOCKS * BLOCK_BYTES;
    localparam int PRINT_CAP  = 100;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] buffer_address;
    } t_alloc_result;

    logic [BLOCKS-1:0] block_map;
    t_alloc_result     expected_results[$];

    task automatic report_mismatch(input string msg);
        o_fail_count++;
        if (o_fail_count <= PRINT_CAP) begin
            $display("%0t: mismatch: %s", $time, msg);
        end
    endtask

    // First-fit allocate / clipped release against the local copy of the map.
    function automatic t_alloc_result apply_request(input logic mode, input logic [15:0] bytes,
                                                    input logic [15:0] addr);
        t_alloc_result res;
        int            need;
        int            run;
        int            start;
        int            first;
        bit            found;
        res.status         = ST_DONE;
        res.buffer_address = '0;
        need               = (int'(bytes) + BLOCK_BYTES - 1) / BLOCK_BYTES;
        if (mode == MODE_ALLOC) begin
            if (need == 0) begin
                res.status = ST_BAD;
            end else begin
                run   = 0;
                start = 0;
                found = 1'b0;
                for (int b = 0; b < BLOCKS && !found; b++) begin
                    if (block_map[b]) begin
                        run = 0;
                    end else begin
                        if (run == 0) start = b;
                        run++;
                        if (run == need) found = 1'b1;
                    end
                end
                if (found) begin
                    for (int b = start; b < start + need; b++) block_map[b] = 1'b1;
                    res.buffer_address = 16'(WINDOW_BASE + start * BLOCK_BYTES);
                end else begin
                    res.status = ST_NO_ROOM;
                end
            end
        end else begin
            if (int'(addr) < WINDOW_BASE || int'(addr) >= WINDOW_END) begin
                res.status = ST_BAD;
            end else begin
                first = (int'(addr) - WINDOW_BASE) / BLOCK_BYTES;
                for (int b = first; b < first + need && b < BLOCKS; b++) block_map[b] = 1'b0;
            end
        end
        return res;
    endfunction

    always @(posedge i_clk) begin : watch
        t_alloc_result seen;
        t_alloc_result want;
        if (!i_rst_n) begin
            block_map = '0;
            expected_results.delete();
        end else begin
            if (i_rsp_valid && i_rsp_ready) begin
                seen.status         = i_status;
                seen.buffer_address = i_buffer_address;
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("unexpected result: status %0d address 0x%04h",
                                              seen.status, seen.buffer_address));
                end else begin
                    want = expected_results.pop_front();
                    if (seen.status !== want.status) begin
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  seen.status, want.status));
                    end
                    if (seen.buffer_address !== want.buffer_address) begin
                        report_mismatch($sformatf("buffer address 0x%04h, expected 0x%04h",
                                                  seen.buffer_address, want.buffer_address));
                    end
                end
            end
            if (i_req_valid && i_req_ready) begin
                expected_results.push_back(apply_request(i_mode, i_byte_count,
                                                         i_release_address));
            end
        end
        o_pending = expected_results.size();
    end

endmodule

// ===== bench/testbench.sv =====
// Testbench top for the block allocator: clock, reset, request and response drivers, verdict.
module testbench;
    import cbba_pkg::*;

    localparam int BLOCKS       = 54;
    localparam int BLOCK_BYTES  = 512;
    localparam int WINDOW_BASE  = 4096;
    localparam int WINDOW_END   = WINDOW_BASE + BLOCKS * BLOCK_BYTES;
    localparam int RANDOM_ITEMS = 1950;
    localparam int DRAIN_LIMIT  = 20000;
    localparam int SETTLE_TAIL  = 200;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        req_valid;
    logic        req_ready;
    logic        req_mode;
    logic [15:0] req_byte_count;
    logic [15:0] req_release_address;
    logic        rsp_valid;
    logic        rsp_ready;
    logic [1:0]  rsp_status;
    logic [15:0] rsp_buffer_address;
    int          fail_count;
    int          pending;
    int          rx_cycle = 0;
    bit          tx_steady = 1'b0;

    always #5 clk = ~clk;

    contiguous_block_bitmap_allocator #(
        .BLOCKS      (BLOCKS),
        .BLOCK_BYTES (BLOCK_BYTES),
        .WINDOW_BASE (WINDOW_BASE)
    ) i_dut (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_valid           (req_valid),
        .o_ready           (req_ready),
        .i_mode            (req_mode),
        .i_byte_count      (req_byte_count),
        .i_release_address (req_release_address),
        .o_valid           (rsp_valid),
        .i_ready           (rsp_ready),
        .o_status          (rsp_status),
        .o_buffer_address  (rsp_buffer_address)
    );

    block_alloc_checker #(
        .BLOCKS      (BLOCKS),
        .BLOCK_BYTES (BLOCK_BYTES),
        .WINDOW_BASE (WINDOW_BASE)
    ) i_checker (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_req_valid       (req_valid),
        .i_req_ready       (req_ready),
        .i_mode            (req_mode),
        .i_byte_count      (req_byte_count),
        .i_release_address (req_release_address),
        .i_rsp_valid       (rsp_valid),
        .i_rsp_ready       (rsp_ready),
        .i_status          (rsp_status),
        .i_buffer_address  (rsp_buffer_address),
        .o_fail_count      (fail_count),
        .o_pending         (pending)
    );

    // Response side: random stalls, two long hold-offs to back up the block, a steady stretch.
    always @(negedge clk) begin
        if (!rst_n) begin
            rsp_ready <= 1'b0;
        end else begin
            rx_cycle <= rx_cycle + 1;
            if ((rx_cycle >= 3000 && rx_cycle < 3400) || (rx_cycle >= 40000 && rx_cycle < 40300)) begin
                rsp_ready <= 1'b0;
            end else if (rx_cycle >= 20000 && rx_cycle < 35000) begin
                rsp_ready <= 1'b1;
            end else begin
                rsp_ready <= ($urandom_range(99) >= 31);
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_request(input logic mode, input logic [15:0] bytes,
                                input logic [15:0] addr);
        while (!tx_steady && $urandom_range(99) < 31) begin
            req_valid = 1'b0;
            @(negedge clk);
        end
        req_valid           = 1'b1;
        req_mode            = mode;
        req_byte_count      = bytes;
        req_release_address = addr;
        do @(posedge clk); while (!req_ready);
        @(negedge clk);
    endtask

    function automatic logic [15:0] bytes_for(input int nblocks);
        return 16'((nblocks - 1) * BLOCK_BYTES + $urandom_range(BLOCK_BYTES, 1));
    endfunction

    initial begin
        int kind;
        int nb;
        int blk;
        int drain;
        rst_n               = 1'b0;
        req_valid           = 1'b0;
        req_mode            = MODE_ALLOC;
        req_byte_count      = '0;
        req_release_address = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_request(MODE_ALLOC, 16'd0, 16'hFFFF);
        send_request(MODE_ALLOC, 16'd1, 16'h0000);
        send_request(MODE_ALLOC, 16'(BLOCK_BYTES), 16'h1234);
        send_request(MODE_ALLOC, 16'(BLOCK_BYTES + 1), 16'h0000);
        send_request(MODE_ALLOC, 16'hFFFF, 16'h0000);
        send_request(MODE_ALLOC, 16'(BLOCKS * BLOCK_BYTES), 16'h0000);
        send_request(MODE_RELEASE, 16'(BLOCK_BYTES), 16'(WINDOW_BASE - 1));
        send_request(MODE_RELEASE, 16'(BLOCK_BYTES), 16'(WINDOW_END));
        send_request(MODE_RELEASE, 16'hFFFF, 16'(WINDOW_END - 1));
        send_request(MODE_RELEASE, 16'd1, 16'(WINDOW_BASE + BLOCK_BYTES + 5));
        send_request(MODE_RELEASE, 16'd0, 16'(WINDOW_BASE));
        send_request(MODE_RELEASE, 16'd1, 16'(WINDOW_BASE + BLOCK_BYTES));
        send_request(MODE_ALLOC, 16'(BLOCK_BYTES), 16'h0000);
        send_request(MODE_RELEASE, 16'hFFFF, 16'(WINDOW_BASE));
        send_request(MODE_ALLOC, 16'(BLOCKS * BLOCK_BYTES), 16'h0000);
        send_request(MODE_ALLOC, 16'd1, 16'h0000);
        send_request(MODE_RELEASE, 16'hFFFF, 16'hFFFF);
        send_request(MODE_RELEASE, 16'(BLOCKS * BLOCK_BYTES), 16'(WINDOW_BASE));
        send_request(MODE_ALLOC, 16'((BLOCKS - 1) * BLOCK_BYTES + 1), 16'hFFFF);
        send_request(MODE_RELEASE, 16'd1, 16'(WINDOW_END - BLOCK_BYTES));
        send_request(MODE_ALLOC, 16'd1, 16'h0000);
        send_request(MODE_RELEASE, 16'd0, 16'h0000);
        send_request(MODE_RELEASE, 16'hFFFF, 16'(WINDOW_BASE));

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            tx_steady = (n >= 700 && n < 900);
            kind = $urandom_range(99);
            if (kind < 52) begin
                nb = ($urandom_range(19) == 0) ? $urandom_range(BLOCKS, 7) : $urandom_range(6, 1);
                send_request(MODE_ALLOC, bytes_for(nb), 16'($urandom));
            end else if (kind < 88) begin
                blk = $urandom_range(BLOCKS - 1);
                nb  = ($urandom_range(9) == 0) ? $urandom_range(60, 9) : $urandom_range(8, 1);
                send_request(MODE_RELEASE,
                             ($urandom_range(9) == 0) ? 16'd0 : bytes_for(nb),
                             16'(WINDOW_BASE + blk * BLOCK_BYTES + $urandom_range(BLOCK_BYTES - 1)));
            end else begin
                send_request(1'($urandom_range(1)), 16'($urandom), 16'($urandom));
            end
        end
        req_valid = 1'b0;

        for (drain = 0; pending != 0 && drain < DRAIN_LIMIT; drain++) @(negedge clk);
        repeat (SETTLE_TAIL) @(negedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #30_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
